>>> rtl/fraction_lcm_unit_defines.svh
// ---------------------------------------------------------------------------
// fraction_lcm_unit_defines
// Assertion macros shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef FRACTION_LCM_UNIT_DEFINES_SVH
`define FRACTION_LCM_UNIT_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define FLU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define FLU_ASSERT_NEXT(label, cond, expect_next, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (expect_next)) else $error(msg);

`endif

>>> rtl/flu_pkg.sv
// ---------------------------------------------------------------------------
// flu_pkg
// Shared types and command codes for the fraction lcm unit.
// ---------------------------------------------------------------------------
package flu_pkg;

    localparam int WORD_BITS = 64;

    typedef logic [WORD_BITS-1:0] word_t;

    // Datapath operations started by the controller.
    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_LOAD     = 4'd1,  // latch operands into registers
        OP_GCD1     = 4'd2,  // g = gcd(t1, b1)
        OP_RED1     = 4'd3,  // t1 /= g, b1 /= g
        OP_GCD2     = 4'd4,
        OP_RED2     = 4'd5,
        OP_GCDT     = 4'd6,  // g = gcd(t1, t2)
        OP_LCM      = 4'd7,  // p = t1 * (t2 / g)
        OP_QTERMS   = 4'd8,  // x = (p/t1)*b1, y = (p/t2)*b2
        OP_GCDQ     = 4'd9,  // q = gcd(x, y)
        OP_GCDP     = 4'd10, // g = gcd(p, q)
        OP_REDP     = 4'd11  // p /= g, q /= g
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic zero_operand;
    } status_t;

endpackage

>>> rtl/fraction_lcm_unit.sv
// ---------------------------------------------------------------------------
// fraction_lcm_unit
// LCM of two fractions: reduce both, p = lcm(tops), q = gcd of scaled
// bottoms, return p/q reduced.
// ---------------------------------------------------------------------------
// Channel  Ports                                          Handshake
// in       first_top first_bottom second_top second_bottom  in_valid/in_ready
// out      result_top result_bottom is_whole bad_input     out_valid/out_ready
//
// One item at a time; every Euclid step and every quotient costs one pass of
// the shared radix-2 divider. Nine quotients and at least five Euclid steps
// make up an item; long Euclid chains add one divider pass per step.
// A zero operand skips the arithmetic.
// Reset is asynchronous and clears the controller, the sequencer and the output valid.
// A stalled result holds; the next item is taken and computed meanwhile and
// waits for that transfer before it is captured.
// ---------------------------------------------------------------------------
module fraction_lcm_unit #(
    parameter int OPERAND_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [OPERAND_BITS-1:0] first_top,
    input  logic [OPERAND_BITS-1:0] first_bottom,
    input  logic [OPERAND_BITS-1:0] second_top,
    input  logic [OPERAND_BITS-1:0] second_bottom,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [63:0]             result_top,
    output logic [63:0]             result_bottom,
    output logic                    is_whole,
    output logic                    bad_input
);

    flu_pkg::cmd_t    cmd;
    flu_pkg::status_t status;
    flu_pkg::word_t   p_w, q_w;
    logic             capture;
    logic [63:0]      top_reg, bottom_reg;
    logic             whole_reg, bad_reg;

    flu_controller u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .capture   (capture)
    );

    flu_datapath #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .first_top     (first_top),
        .first_bottom  (first_bottom),
        .second_top    (second_top),
        .second_bottom (second_bottom),
        .cmd           (cmd),
        .status        (status),
        .p_out         (p_w),
        .q_out         (q_w)
    );

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            bad_reg    <= status.zero_operand;
            top_reg    <= status.zero_operand ? '0 : p_w;
            bottom_reg <= status.zero_operand ? '0 : q_w;
            whole_reg  <= !status.zero_operand && (q_w == 64'd1);
        end
    end

    assign result_top    = top_reg;
    assign result_bottom = bottom_reg;
    assign is_whole      = whole_reg;
    assign bad_input     = bad_reg;

endmodule

>>> rtl/flu_divider.sv
// ---------------------------------------------------------------------------
// flu_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module flu_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  flu_pkg::word_t     dividend,
    input  flu_pkg::word_t     divisor,
    output logic               busy,
    output flu_pkg::word_t     quotient,
    output flu_pkg::word_t     remainder
);

    localparam int CNT_BITS = $clog2(flu_pkg::WORD_BITS + 1);

    flu_pkg::word_t       quo_reg;
    flu_pkg::word_t       rem_reg;
    flu_pkg::word_t       dvs_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 busy_reg;

    logic [flu_pkg::WORD_BITS:0] trial;
    logic [flu_pkg::WORD_BITS:0] shifted;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[flu_pkg::WORD_BITS-1]};
        trial   = shifted - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_BITS'(flu_pkg::WORD_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // restore when the trial subtraction goes negative
            if (!trial[flu_pkg::WORD_BITS])
            begin
                rem_reg <= trial[flu_pkg::WORD_BITS-1:0];
                quo_reg <= {quo_reg[flu_pkg::WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[flu_pkg::WORD_BITS-1:0];
                quo_reg <= {quo_reg[flu_pkg::WORD_BITS-2:0], 1'b0};
            end
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/flu_datapath.sv
// ---------------------------------------------------------------------------
// flu_datapath
// Operand registers, one shared divider and one 32x32 multiplier; runs the
// operation it is told and reports done.
// ---------------------------------------------------------------------------
`include "fraction_lcm_unit_defines.svh"

module flu_datapath #(
    parameter int OPERAND_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [OPERAND_BITS-1:0] first_top,
    input  logic [OPERAND_BITS-1:0] first_bottom,
    input  logic [OPERAND_BITS-1:0] second_top,
    input  logic [OPERAND_BITS-1:0] second_bottom,
    input  flu_pkg::cmd_t           cmd,
    output flu_pkg::status_t        status,
    output flu_pkg::word_t          p_out,
    output flu_pkg::word_t          q_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD_TEST,   // check y == 0
        S_GCD_WAIT,   // x % y in flight
        S_DIV_A,      // first quotient in flight
        S_DIV_B,      // second quotient in flight
        S_MUL_A,      // first product
        S_MUL_B,      // second product
        S_DONE
    } sub_t;

    sub_t            sub_reg;
    flu_pkg::op_t    op_reg;
    flu_pkg::word_t  t1_reg, b1_reg, t2_reg, b2_reg, p_reg, q_reg, g_reg;
    flu_pkg::word_t  x_reg, y_reg;
    flu_pkg::word_t  qa_reg;
    logic            zero_reg;

    logic            div_start;
    logic            div_busy;
    flu_pkg::word_t  div_a, div_b, div_q, div_r;
    flu_pkg::word_t  first_a, first_b, second_a, second_b;
    logic            is_div_op;
    logic            two_quot;
    logic [31:0]     mul_a, mul_b;
    flu_pkg::word_t  mul_p;

    flu_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        unique case (cmd.op) inside
            flu_pkg::OP_RED1, flu_pkg::OP_RED2, flu_pkg::OP_LCM,
            flu_pkg::OP_QTERMS, flu_pkg::OP_REDP:
                is_div_op = 1'b1;
            default:
                is_div_op = 1'b0;
        endcase
    end

    assign two_quot = (op_reg != flu_pkg::OP_LCM);

    always_comb
    begin
        case (cmd.op)
            flu_pkg::OP_RED1:   begin first_a = t1_reg; first_b = g_reg;  end
            flu_pkg::OP_RED2:   begin first_a = t2_reg; first_b = g_reg;  end
            flu_pkg::OP_LCM:    begin first_a = t2_reg; first_b = g_reg;  end
            flu_pkg::OP_QTERMS: begin first_a = p_reg;  first_b = t1_reg; end
            flu_pkg::OP_REDP:   begin first_a = p_reg;  first_b = g_reg;  end
            default:            begin first_a = x_reg;  first_b = y_reg;  end
        endcase
    end

    always_comb
    begin
        case (op_reg)
            flu_pkg::OP_RED1:   begin second_a = b1_reg; second_b = g_reg;  end
            flu_pkg::OP_RED2:   begin second_a = b2_reg; second_b = g_reg;  end
            flu_pkg::OP_QTERMS: begin second_a = p_reg;  second_b = t2_reg; end
            flu_pkg::OP_REDP:   begin second_a = q_reg;  second_b = g_reg;  end
            default:            begin second_a = x_reg;  second_b = y_reg;  end
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_a     = x_reg;
        div_b     = y_reg;
        unique case (sub_reg)
            S_IDLE:
                if (cmd.start && is_div_op)
                begin
                    div_start = 1'b1;
                    div_a     = first_a;
                    div_b     = first_b;
                end
            S_GCD_TEST:
                div_start = (y_reg != '0);
            S_DIV_A:
                if (!div_busy && two_quot)
                begin
                    div_start = 1'b1;
                    div_a     = second_a;
                    div_b     = second_b;
                end
            default: ;
        endcase
    end

    // reduced operands and the lcm quotients fit in 32 bits
    always_comb
    begin
        mul_a = qa_reg[31:0];
        mul_b = b1_reg[31:0];
        if (sub_reg == S_MUL_B)
        begin
            mul_a = div_q[31:0];
            mul_b = b2_reg[31:0];
        end
        else if (op_reg == flu_pkg::OP_LCM)
        begin
            mul_a = t1_reg[31:0];
            mul_b = qa_reg[31:0];
        end
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg  <= S_IDLE;
            op_reg   <= flu_pkg::OP_NONE;
            zero_reg <= 1'b0;
        end
        else
        begin
            unique case (sub_reg)
                S_IDLE:
                begin
                    if (cmd.start)
                    begin
                        op_reg <= cmd.op;
                        unique case (cmd.op) inside
                            flu_pkg::OP_LOAD:
                            begin
                                zero_reg <= (first_top == '0) || (first_bottom == '0) ||
                                            (second_top == '0) || (second_bottom == '0);
                                sub_reg  <= S_DONE;
                            end
                            flu_pkg::OP_GCD1, flu_pkg::OP_GCD2, flu_pkg::OP_GCDT,
                            flu_pkg::OP_GCDQ, flu_pkg::OP_GCDP:
                                sub_reg <= S_GCD_TEST;
                            flu_pkg::OP_RED1, flu_pkg::OP_RED2, flu_pkg::OP_LCM,
                            flu_pkg::OP_QTERMS, flu_pkg::OP_REDP:
                                sub_reg <= S_DIV_A;
                            default:
                                sub_reg <= S_DONE;
                        endcase
                    end
                end
                S_GCD_TEST:
                    sub_reg <= (y_reg == '0) ? S_DONE : S_GCD_WAIT;
                S_GCD_WAIT:
                    if (!div_busy) sub_reg <= S_GCD_TEST;
                S_DIV_A:
                    if (!div_busy) sub_reg <= two_quot ? S_DIV_B : S_MUL_A;
                S_DIV_B:
                    if (!div_busy)
                        sub_reg <= (op_reg == flu_pkg::OP_QTERMS) ? S_MUL_A : S_DONE;
                S_MUL_A:
                    sub_reg <= (op_reg == flu_pkg::OP_QTERMS) ? S_MUL_B : S_DONE;
                S_MUL_B:
                    sub_reg <= S_DONE;
                S_DONE:
                    sub_reg <= S_IDLE;
                default:
                    sub_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (sub_reg)
            S_IDLE:
                if (cmd.start)
                begin
                    case (cmd.op)
                        flu_pkg::OP_LOAD:
                        begin
                            t1_reg <= flu_pkg::word_t'(first_top);
                            b1_reg <= flu_pkg::word_t'(first_bottom);
                            t2_reg <= flu_pkg::word_t'(second_top);
                            b2_reg <= flu_pkg::word_t'(second_bottom);
                        end
                        flu_pkg::OP_GCD1: begin x_reg <= t1_reg; y_reg <= b1_reg; end
                        flu_pkg::OP_GCD2: begin x_reg <= t2_reg; y_reg <= b2_reg; end
                        flu_pkg::OP_GCDT: begin x_reg <= t1_reg; y_reg <= t2_reg; end
                        // g = gcd(p, q); OP_GCDQ finds the scaled bottoms already left in x and y
                        flu_pkg::OP_GCDP: begin x_reg <= p_reg;  y_reg <= q_reg;  end
                        default: ;
                    endcase
                end
            S_GCD_TEST:
                if (y_reg == '0)
                begin
                    g_reg <= x_reg;
                    if (op_reg == flu_pkg::OP_GCDQ)
                        q_reg <= x_reg;
                end
            S_GCD_WAIT:
                if (!div_busy)
                begin
                    x_reg <= y_reg;
                    y_reg <= div_r;
                end
            S_DIV_A:
                if (!div_busy)
                begin
                    qa_reg <= div_q;
                    case (op_reg)
                        flu_pkg::OP_RED1: t1_reg <= div_q;
                        flu_pkg::OP_RED2: t2_reg <= div_q;
                        flu_pkg::OP_REDP: p_reg  <= div_q;
                        default: ;
                    endcase
                end
            S_DIV_B:
                if (!div_busy)
                begin
                    case (op_reg)
                        flu_pkg::OP_RED1: b1_reg <= div_q;
                        flu_pkg::OP_RED2: b2_reg <= div_q;
                        flu_pkg::OP_REDP: q_reg  <= div_q;
                        default: ;
                    endcase
                end
            S_MUL_A:
                if (op_reg == flu_pkg::OP_LCM)
                    p_reg <= mul_p;
                else
                    x_reg <= mul_p;
            // divider holds p/t2 while idle
            S_MUL_B:
                y_reg <= mul_p;
            default: ;
        endcase
    end

    assign status.done         = (sub_reg == S_DONE);
    assign status.zero_operand = zero_reg;
    assign p_out               = p_reg;
    assign q_out               = q_reg;

    `FLU_ASSERT_NEXT(a_done_pulse, sub_reg == S_DONE, sub_reg == S_IDLE, "done held too long")
    `FLU_ASSERT(a_no_start_busy, !(div_start && div_busy), "divider restarted while busy")
    `FLU_ASSERT(a_div_nonzero, !div_start || (div_b != '0), "division by zero started")

endmodule

>>> rtl/flu_controller.sv
// ---------------------------------------------------------------------------
// flu_controller
// Sequences the datapath operations for one item and runs the handshakes.
// ---------------------------------------------------------------------------
`include "fraction_lcm_unit_defines.svh"

module flu_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  flu_pkg::status_t  status,
    output flu_pkg::cmd_t     cmd,
    output logic              capture
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_ISSUE,
        C_WAIT,
        C_FLUSH
    } ctl_t;

    ctl_t         state_reg;
    flu_pkg::op_t op_reg;
    logic         out_valid_reg;
    logic         cap_reg;
    logic         last_done;

    // next op after the current one; OP_NONE marks the end of the sequence
    function automatic flu_pkg::op_t next_op(input flu_pkg::op_t op);
        unique case (op)
            flu_pkg::OP_LOAD:   next_op = flu_pkg::OP_GCD1;
            flu_pkg::OP_GCD1:   next_op = flu_pkg::OP_RED1;
            flu_pkg::OP_RED1:   next_op = flu_pkg::OP_GCD2;
            flu_pkg::OP_GCD2:   next_op = flu_pkg::OP_RED2;
            flu_pkg::OP_RED2:   next_op = flu_pkg::OP_GCDT;
            flu_pkg::OP_GCDT:   next_op = flu_pkg::OP_LCM;
            flu_pkg::OP_LCM:    next_op = flu_pkg::OP_QTERMS;
            flu_pkg::OP_QTERMS: next_op = flu_pkg::OP_GCDQ;
            flu_pkg::OP_GCDQ:   next_op = flu_pkg::OP_GCDP;
            flu_pkg::OP_GCDP:   next_op = flu_pkg::OP_REDP;
            default:            next_op = flu_pkg::OP_NONE;
        endcase
    endfunction

    assign in_ready  = (state_reg == C_IDLE);
    assign out_valid = out_valid_reg;
    assign capture   = cap_reg;

    // zero operand: skip the arithmetic
    assign last_done = status.done &&
                       (next_op(op_reg) == flu_pkg::OP_NONE ||
                        (op_reg == flu_pkg::OP_LOAD && status.zero_operand));

    // load the operands in the transfer cycle
    always_comb
    begin
        cmd.start = 1'b0;
        cmd.op    = op_reg;
        if (state_reg == C_IDLE)
        begin
            cmd.start = in_valid;
            cmd.op    = flu_pkg::OP_LOAD;
        end
        else if (state_reg == C_ISSUE)
            cmd.start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            op_reg        <= flu_pkg::OP_NONE;
            out_valid_reg <= 1'b0;
            cap_reg       <= 1'b0;
        end
        else
        begin
            // capture only once the previous result has gone
            cap_reg <= (state_reg == C_FLUSH) && (!out_valid_reg || out_ready);
            if (cap_reg)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                    if (in_valid)
                    begin
                        op_reg    <= flu_pkg::OP_LOAD;
                        state_reg <= C_WAIT;
                    end
                C_ISSUE:
                    state_reg <= C_WAIT;
                C_WAIT:
                    if (status.done)
                    begin
                        if (last_done)
                            state_reg <= C_FLUSH;
                        else
                        begin
                            op_reg    <= next_op(op_reg);
                            state_reg <= C_ISSUE;
                        end
                    end
                C_FLUSH:
                    if (!out_valid_reg || out_ready)
                        state_reg <= C_IDLE;
                default:
                    state_reg <= C_IDLE;
            endcase
        end
    end

    `FLU_ASSERT_NEXT(a_hold_valid, out_valid_reg && !out_ready, out_valid_reg, "result dropped")
    `FLU_ASSERT(a_no_accept_busy, !(in_valid && in_ready) || state_reg == C_IDLE, "accept busy")
    `FLU_ASSERT(a_cap_free, !(cap_reg && out_valid_reg), "capture over a waiting result")

endmodule

>>> bench/fraction_lcm_checker.sv
// ---------------------------------------------------------------------------
// fraction_lcm_checker
// Watches both channels of the fraction lcm unit. Computes the expected
// result for every input transfer and compares each output transfer with it.
// ---------------------------------------------------------------------------
module fraction_lcm_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] first_top,
    input  logic [31:0] first_bottom,
    input  logic [31:0] second_top,
    input  logic [31:0] second_bottom,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] result_top,
    input  logic [63:0] result_bottom,
    input  logic        is_whole,
    input  logic        bad_input,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [63:0] top;
        logic [63:0] bottom;
        logic        whole;
        logic        bad;
    } fraction_result_t;

    fraction_result_t lcm_queue[$];
    int               fails = 0;
    int               queued = 0;

    function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic fraction_result_t fraction_lcm(logic [31:0] a, logic [31:0] b,
                                                      logic [31:0] c, logic [31:0] d);
        fraction_result_t res;
        logic [63:0] t1, b1, t2, b2, g, p, q;
        res = '{64'd0, 64'd0, 1'b0, 1'b0};
        if (a == 0 || b == 0 || c == 0 || d == 0)
        begin
            res.bad = 1'b1;
            return res;
        end
        t1 = a;
        b1 = b;
        t2 = c;
        b2 = d;
        g = euclid_gcd(t1, b1);
        t1 = t1 / g;
        b1 = b1 / g;
        g = euclid_gcd(t2, b2);
        t2 = t2 / g;
        b2 = b2 / g;
        g = euclid_gcd(t1, t2);
        p = t1 * (t2 / g);
        q = euclid_gcd((p / t1) * b1, (p / t2) * b2);
        g = euclid_gcd(p, q);
        p = p / g;
        q = q / g;
        res.top = p;
        res.bottom = q;
        res.whole = (q == 64'd1);
        return res;
    endfunction

    assign fail_count = fails;
    assign pending    = queued;

    always @(posedge clk)
    begin
        fraction_result_t exp_res;
        if (rst_n && in_valid && in_ready)
            lcm_queue.push_back(fraction_lcm(first_top, first_bottom,
                                             second_top, second_bottom));
        if (rst_n && out_valid && out_ready)
        begin
            if (lcm_queue.size() == 0)
            begin
                $error("result transfer with nothing expected");
                fails++;
            end
            else
            begin
                exp_res = lcm_queue.pop_front();
                if (result_top !== exp_res.top)
                begin
                    $error("result_top expected %0d actual %0d", exp_res.top, result_top);
                    fails++;
                end
                if (result_bottom !== exp_res.bottom)
                begin
                    $error("result_bottom expected %0d actual %0d",
                           exp_res.bottom, result_bottom);
                    fails++;
                end
                if (is_whole !== exp_res.whole)
                begin
                    $error("is_whole expected %0b actual %0b", exp_res.whole, is_whole);
                    fails++;
                end
                if (bad_input !== exp_res.bad)
                begin
                    $error("bad_input expected %0b actual %0b", exp_res.bad, bad_input);
                    fails++;
                end
            end
        end
        queued = lcm_queue.size();
    end

endmodule

>>> bench/tb.sv
// ---------------------------------------------------------------------------
// tb
// Stimulus for the fraction lcm unit: directed corner fractions, then
// random fractions of mixed operand widths under varying flow control.
// ---------------------------------------------------------------------------
module tb;

    localparam int ITEMS_PER_PHASE = 500;
    localparam longint CYCLE_LIMIT = 150_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] first_top = '0;
    logic [31:0] first_bottom = '0;
    logic [31:0] second_top = '0;
    logic [31:0] second_bottom = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] result_top;
    logic [63:0] result_bottom;
    logic        is_whole;
    logic        bad_input;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    longint      cycle_count = 0;

    always #6 clk = ~clk;

    fraction_lcm_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .first_top(first_top), .first_bottom(first_bottom),
        .second_top(second_top), .second_bottom(second_bottom),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_top(result_top), .result_bottom(result_bottom),
        .is_whole(is_whole), .bad_input(bad_input)
    );

    fraction_lcm_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .first_top(first_top), .first_bottom(first_bottom),
        .second_top(second_top), .second_bottom(second_bottom),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_top(result_top), .result_bottom(result_bottom),
        .is_whole(is_whole), .bad_input(bad_input),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("fraction_lcm_unit verification failed");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_fractions(logic [31:0] a, logic [31:0] b,
                                  logic [31:0] c, logic [31:0] d);
        int gap;
        first_top <= a;
        first_bottom <= b;
        second_top <= c;
        second_bottom <= d;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Mixed widths keep most Euclid loops short; zero now and then.
    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        int bits;
        if ($urandom_range(99) < 2)
            return 32'd0;
        bits = $urandom_range(1, 32);
        v = $urandom;
        if (bits < 32)
            v = v & ((32'd1 << bits) - 1);
        return (v == 0) ? 32'd1 : v;
    endfunction

    task automatic random_phase(int s_pct, int r_pct);
        logic [31:0] a, c;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < ITEMS_PER_PHASE; i++)
        begin
            a = rand_operand();
            c = rand_operand();
            // Related tops exercise the lcm path with large common factors.
            if ($urandom_range(9) == 0 && a != 0)
                c = a * $urandom_range(1, 7);
            send_fractions(a, rand_operand(), c, rand_operand());
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 23;
        recv_idle_pct = 46;
        send_fractions(32'd0, 32'd1, 32'd1, 32'd1);
        send_fractions(32'd1, 32'd0, 32'd1, 32'd1);
        send_fractions(32'd1, 32'd1, 32'd0, 32'd1);
        send_fractions(32'd1, 32'd1, 32'd1, 32'd0);
        send_fractions(32'd0, 32'd0, 32'd0, 32'd0);
        send_fractions(32'd1, 32'd1, 32'd1, 32'd1);
        send_fractions(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fractions(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFE, 32'd1);
        send_fractions(32'd1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFE);
        send_fractions(32'hFFFF_FFFB, 32'hFFFF_FFF1, 32'hFFFF_FFF1, 32'hFFFF_FFFB);
        send_fractions(32'd2, 32'd3, 32'd4, 32'd5);
        send_fractions(32'd6, 32'd4, 32'd9, 32'd6);
        send_fractions(32'd12, 32'd18, 32'd12, 32'd18);
        send_fractions(32'd7, 32'd1, 32'd7, 32'd3);
        send_fractions(32'd2971215073, 32'd1836311903, 32'd1836311903, 32'd1134903170);
        send_fractions(32'h8000_0000, 32'h4000_0000, 32'h0001_0000, 32'h8000_0000);
        send_fractions(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);
        send_fractions(32'd65536, 32'd3, 32'd65537, 32'd5);
        // Hold off until the pipeline has drained.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        random_phase(23, 46);
        random_phase(46, 23);
        random_phase(0, 0);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("fraction_lcm_unit verification clean");
        else
            $display("fraction_lcm_unit verification failed");
        $finish;
    end

endmodule
